>>> hdl/lhe_pkg.sv
`timescale 1ns / 1ps
// Shared widths, reset values, defaults and register indexes of the local histogram equaliser.
package lhe_pkg;

   // Fixed field widths.
   localparam int PIXEL_W    = 8;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_PADDED_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PADDED_HEIGHT = 1'd1;

   // Register values after reset.
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1024;

   // Default geometry.
   localparam int DEF_WINDOW_SIZE = 7;
   localparam int DEF_MAX_LINE    = 1024;

   // Fraction bits of the reciprocal used for the division by the window area.
   localparam int RECIP_SHIFT = 32;

endpackage

>>> hdl/local_histogram_equalizer.sv
`timescale 1ns / 1ps
// Local histogram equaliser: streaming rank filter over a square window of a padded image.
//
// The block takes a zero-padded 8-bit grey image in raster order, one pixel per
// request, and for every position where the WINDOW_SIZE by WINDOW_SIZE window lies
// wholly inside the image it returns round(count * 255 / area), count being the
// number of window pixels at or below the centre pixel. It sustains one pixel per
// clock cycle while the skid register is free: the line store is a single RAM, one
// entry per column holding that column's previous WINDOW_SIZE-1 rows, which is read
// and written back once per pixel, with forwarding when a pixel hits the column
// that the pixel before it is writing back. The line-store read happens at the
// accepting edge, then come window shift, per-row compare counts, row sum and
// scale, reciprocal multiply, back multiply, and correction into the output
// register. An output register plus one skid register hold results; the input is
// held off only while both are full. The line store needs no clearing pass after
// reset: a correct stream never reads an entry it has not written. Configuration
// writes take effect at once and should be made between frames; a frame_start flag
// on tuser restarts the row and column counters.
module local_histogram_equalizer #(
   parameter int WINDOW_SIZE = lhe_pkg::DEF_WINDOW_SIZE,
   parameter int MAX_LINE    = lhe_pkg::DEF_MAX_LINE
) (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration write port.
   input  logic                             csr_wr_en,
   input  logic [lhe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lhe_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   // Pixel requests.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lhe_pkg::PIXEL_W-1:0]      req_tdata,   // [7:0] pixel
   input  logic                             req_tuser,   // [0] frame_start
   // Equalised results.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lhe_pkg::PIXEL_W-1:0]      rsp_tdata,   // [7:0] out_pixel
   output logic                             rsp_tlast
);

   import lhe_pkg::*;

   localparam int STORE_ROWS = WINDOW_SIZE - 1;
   localparam int STORE_W    = STORE_ROWS * PIXEL_W;
   localparam int SLOT_W     = $clog2(STORE_ROWS);
   localparam int COL_W      = $clog2(MAX_LINE);
   localparam int LEN_W      = $clog2(MAX_LINE + 1);
   localparam int WIN_AREA   = WINDOW_SIZE * WINDOW_SIZE;
   localparam int HALF_AREA  = WIN_AREA / 2;
   localparam int CENTRE     = WINDOW_SIZE / 2;
   localparam int CNT_W      = $clog2(WIN_AREA + 1);
   localparam int ROW_CNT_W  = $clog2(WINDOW_SIZE + 1);
   localparam int X_W        = CNT_W + PIXEL_W;
   localparam int PROD_W     = X_W + RECIP_SHIFT;
   localparam logic [RECIP_SHIFT-1:0] RECIP =
      RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / WIN_AREA);

   // Configuration registers.
   logic [WIDTH_W-1:0]  padded_width_ff;
   logic [HEIGHT_W-1:0] padded_height_ff;
   logic [LEN_W-1:0]    eff_width;

   // Position counters.
   logic [COL_W-1:0]    column_ff, column_in, col_cur;
   logic [HEIGHT_W-1:0] row_ff, row_in, row_cur;
   logic [SLOT_W-1:0]   slot_ff, slot_in, slot_cur;
   logic [LEN_W-1:0]    col_next;
   logic                adv, req_accept, in_frame, take, row_end, emit_cur, last_cur;

   // Line store access and forwarding.
   logic [STORE_W-1:0]  ram_rd_data, store_rd, store_wr;
   logic                fwd_ff, fwd_in;
   logic [STORE_W-1:0]  fwd_data_ff;

   // Stage 1: line-store data returns.
   logic                s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic [PIXEL_W-1:0]  s1_pixel_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic [SLOT_W-1:0]   s1_slot_ff;
   logic [PIXEL_W-1:0]  new_col [WINDOW_SIZE];

   // Stage 2: window registers hold the request's window.
   logic [PIXEL_W-1:0]  window_ff [WINDOW_SIZE][WINDOW_SIZE];
   logic                s2_valid_ff, s2_last_ff;

   // Stage 3: per-row counts.
   logic [ROW_CNT_W-1:0] row_cnt_in [WINDOW_SIZE];
   logic [ROW_CNT_W-1:0] row_cnt_ff [WINDOW_SIZE];
   logic                 s3_valid_ff, s3_last_ff;

   // Stage 4 to 6: scaling and division by the window area.
   logic [CNT_W-1:0]    count_sum;
   logic [X_W-1:0]      x_in, x4_ff, x5_ff, x6_ff;
   logic                s4_valid_ff, s4_last_ff, s5_valid_ff, s5_last_ff;
   logic                s6_valid_ff, s6_last_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PIXEL_W-1:0]  quot_ff;
   logic [X_W-1:0]      qn_ff;
   logic [X_W-1:0]      rem;
   logic [PIXEL_W-1:0]  res_pixel;

   // Output register and skid register.
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [PIXEL_W-1:0]  rsp_pixel_ff, skid_pixel_ff;
   logic                rsp_last_ff, skid_last_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         padded_width_ff  <= WIDTH_RESET;
         padded_height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PADDED_WIDTH: begin
               padded_width_ff <= csr_wr_data[WIDTH_W-1:0];
            end
            CSR_PADDED_HEIGHT: begin
               padded_height_ff <= csr_wr_data[HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The row length in use is the width register clamped to one line store row; a zero width counts as one.
   always_comb begin
      if (padded_width_ff == '0) begin
         eff_width = LEN_W'(1);
      end else if (32'(padded_width_ff) > MAX_LINE) begin
         eff_width = LEN_W'(MAX_LINE);
      end else begin
         eff_width = LEN_W'(padded_width_ff);
      end
   end

   // Handshake: the pipeline moves whenever the skid register is free.
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;
   assign req_accept = req_tvalid && adv;

   // Position of the incoming pixel; a frame start clears the counters first.
   assign col_cur  = req_tuser ? '0 : column_ff;
   assign row_cur  = req_tuser ? '0 : row_ff;
   assign slot_cur = req_tuser ? '0 : slot_ff;
   assign in_frame = row_cur < padded_height_ff;
   assign take     = req_accept && in_frame;
   assign col_next = LEN_W'(col_cur) + LEN_W'(1);
   assign row_end  = col_next >= eff_width;
   assign emit_cur = (32'(row_cur) >= 32'(WINDOW_SIZE - 1)) &&
                     (32'(col_cur) >= 32'(WINDOW_SIZE - 1));
   assign last_cur = (row_cur == padded_height_ff - HEIGHT_W'(1)) &&
                     (LEN_W'(col_cur) == eff_width - LEN_W'(1));

   // Next counter values; pixels past the last row leave them untouched.
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      slot_in   = slot_ff;
      if (req_accept) begin
         column_in = col_cur;
         row_in    = row_cur;
         slot_in   = slot_cur;
         if (in_frame) begin
            if (row_end) begin
               column_in = '0;
               row_in    = row_cur + HEIGHT_W'(1);
               slot_in   = (slot_cur == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_cur + SLOT_W'(1);
            end else begin
               column_in = col_next[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         slot_ff   <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         slot_ff   <= slot_in;
      end
   end

   // Line store: one entry per column, one byte lane per row slot.
   lhe_ram #(
      .WIDTH (STORE_W),
      .DEPTH (MAX_LINE)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (adv && s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (store_wr),
      .rd_en   (adv),
      .rd_addr (col_cur),
      .rd_data (ram_rd_data)
   );

   // A read of the column written in the same cycle takes the written word instead.
   assign fwd_in   = take && s1_valid_ff && (col_cur == s1_col_ff);
   assign store_rd = fwd_ff ? fwd_data_ff : ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (adv) begin
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_data_ff <= store_wr;
      end
   end

   // Stage 1 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pixel_ff <= req_tdata;
         s1_col_ff   <= col_cur;
         s1_slot_ff  <= slot_cur;
         s1_emit_ff  <= emit_cur;
         s1_last_ff  <= last_cur;
      end
   end

   // Unpack the stored rows oldest first and put the new pixel at the bottom.
   always_comb begin
      int k;
      int idx;
      for (k = 1; k <= STORE_ROWS; k++) begin
         if (int'(s1_slot_ff) >= k) begin
            idx = int'(s1_slot_ff) - k;
         end else begin
            idx = int'(s1_slot_ff) + STORE_ROWS - k;
         end
         new_col[WINDOW_SIZE-1-k] = store_rd[idx*PIXEL_W +: PIXEL_W];
      end
      new_col[WINDOW_SIZE-1] = s1_pixel_ff;
   end

   // Write-back word: the current row's slot takes the new pixel.
   always_comb begin
      int s;
      for (s = 0; s < STORE_ROWS; s++) begin
         if (SLOT_W'(s) == s1_slot_ff) begin
            store_wr[s*PIXEL_W +: PIXEL_W] = s1_pixel_ff;
         end else begin
            store_wr[s*PIXEL_W +: PIXEL_W] = store_rd[s*PIXEL_W +: PIXEL_W];
         end
      end
   end

   // Window shifts left by one column per stored pixel.
   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         for (int i = 0; i < WINDOW_SIZE; i++) begin
            for (int j = 0; j < WINDOW_SIZE - 1; j++) begin
               window_ff[i][j] <= window_ff[i][j+1];
            end
            window_ff[i][WINDOW_SIZE-1] <= new_col[i];
         end
      end
   end

   // Count, row by row, the window pixels at or below the centre.
   always_comb begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         row_cnt_in[i] = '0;
         for (int j = 0; j < WINDOW_SIZE; j++) begin
            if (window_ff[i][j] <= window_ff[CENTRE][CENTRE]) begin
               row_cnt_in[i] = row_cnt_in[i] + ROW_CNT_W'(1);
            end
         end
      end
   end

   // Sum the rows and scale: count * 255 plus half the area for rounding.
   always_comb begin
      count_sum = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         count_sum = count_sum + CNT_W'(row_cnt_ff[i]);
      end
      x_in = (X_W'(count_sum) << PIXEL_W) - X_W'(count_sum) + X_W'(HALF_AREA);
   end

   // Valid and last flags through stages 2 to 6.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // Datapath of stages 2 to 6: the quotient estimate is at most one short.
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_last_ff <= s1_last_ff;
         s3_last_ff <= s2_last_ff;
         s4_last_ff <= s3_last_ff;
         s5_last_ff <= s4_last_ff;
         s6_last_ff <= s5_last_ff;
         row_cnt_ff <= row_cnt_in;
         x4_ff      <= x_in;
         prod_ff    <= PROD_W'(x4_ff) * PROD_W'(RECIP);
         x5_ff      <= x4_ff;
         quot_ff    <= prod_ff[RECIP_SHIFT +: PIXEL_W];
         qn_ff      <= X_W'(prod_ff[RECIP_SHIFT +: PIXEL_W]) * X_W'(WIN_AREA);
         x6_ff      <= x5_ff;
      end
   end

   // Correct the estimate where the remainder still holds a whole area.
   assign rem       = x6_ff - qn_ff;
   assign res_pixel = (rem >= X_W'(WIN_AREA)) ? quot_ff + PIXEL_W'(1) : quot_ff;

   // Output register with a skid register behind it.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            skid_valid_in = 1'b0;
         end
      end else if (s6_valid_ff) begin
         if (!rsp_tvalid_ff || rsp_tready) begin
            rsp_tvalid_in = 1'b1;
         end else begin
            skid_valid_in = 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_pixel_ff <= skid_pixel_ff;
            rsp_last_ff  <= skid_last_ff;
         end
      end else if (s6_valid_ff) begin
         if (!rsp_tvalid_ff || rsp_tready) begin
            rsp_pixel_ff <= res_pixel;
            rsp_last_ff  <= s6_last_ff;
         end else begin
            skid_pixel_ff <= res_pixel;
            skid_last_ff  <= s6_last_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The skid register only fills behind a waiting output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_tvalid_ff)
      else $error("skid register holds a result while the output register is empty");

   // A finished result meeting a stalled output is parked, not dropped.
   a_result_parked: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready && !skid_valid_ff && s6_valid_ff) |=> skid_valid_ff)
      else $error("result lost while the output register was stalled");

   // Forwarding is only armed for a stored pixel that follows another stored pixel.
   a_fwd_pair: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> (s1_valid_ff && $past(s1_valid_ff)))
      else $error("line-store forwarding armed without a write before it");

   // Pixels past the last row of the frame never reach the line store.
   a_past_frame_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !in_frame) |=> !s1_valid_ff)
      else $error("pixel beyond the frame entered the pipeline");

   // The reciprocal estimate is never more than one short of the quotient.
   a_recip_bound: assert property (@(posedge clock) disable iff (reset)
      s6_valid_ff |-> (rem < X_W'(2 * WIN_AREA)))
      else $error("division estimate out of range");

endmodule

>>> hdl/lhe_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
module lhe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; the read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the local histogram equaliser: directed and random pixel frames.
module tb;
   import lhe_pkg::*;

   localparam int WIN           = DEF_WINDOW_SIZE;
   localparam int LINE          = DEF_MAX_LINE;
   localparam int HALF          = WIN / 2;
   localparam int AREA          = WIN * WIN;
   localparam int DEPTH         = WIN - 1;
   localparam int CENTRE_INDEX  = HALF * WIN + HALF;
   localparam int FULL_SCALE    = 255;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_SHOWN     = 10;

   // One equalised pixel as it leaves the block.
   typedef struct packed {
      logic [PIXEL_W-1:0] level;
      logic               last;
   } equalised_type;

   // How the grey values of a frame are drawn.
   typedef enum {FULL_RANGE, NARROW, THREE_LEVEL} texture_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = CSR_PADDED_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata   = '0;    // [7:0] pixel
   logic                   req_tuser   = 1'b0;  // [0] frame_start
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [PIXEL_W-1:0]     rsp_tdata;           // [7:0] out_pixel
   logic                   rsp_tlast;

   // Predictor state: line rows, window, position counters and registers.
   logic [PIXEL_W-1:0]  line_copy [DEPTH][LINE];
   logic [PIXEL_W-1:0]  window_copy [WIN][WIN];
   int unsigned         next_col     = 0;
   int unsigned         next_row     = 0;
   logic [WIDTH_W-1:0]  width_reg    = WIDTH_RESET;
   logic [HEIGHT_W-1:0] height_reg   = HEIGHT_RESET;
   equalised_type       expected_q[$];
   int unsigned         taken_pixels = 0;
   int unsigned         error_count  = 0;
   int unsigned         send_idle_pct = 18;
   int unsigned         recv_idle_pct = 76;

   local_histogram_equalizer #(
      .WINDOW_SIZE(WIN),
      .MAX_LINE   (LINE)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // The receiver stalls at random with the current idle rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   function automatic void note_fault(string what);
      error_count++;
      if (error_count <= MAX_SHOWN) $display("%0d ns: %s", $time, what);
   endfunction

   // Predicts the equalised value, if any, that one accepted pixel request gives.
   function automatic void equalise_pixel(logic [PIXEL_W-1:0] px, logic sof);
      int unsigned        eff_w, c, r, count, i, j, k;
      logic [PIXEL_W-1:0] column [WIN];
      logic [PIXEL_W-1:0] centre;
      equalised_type      res;
      eff_w = (width_reg == 0) ? 1 : (width_reg > LINE) ? LINE : width_reg;
      if (sof) begin
         next_col = 0;
         next_row = 0;
      end
      // Pixels beyond the last row are dropped until the next frame start.
      if (next_row >= height_reg) return;
      taken_pixels++;
      c = (next_col >= LINE) ? LINE - 1 : next_col;
      r = next_row;
      // New window column: oldest row at the top, the current pixel at the bottom.
      for (k = 1; k <= DEPTH; k++) column[WIN-1-k] = line_copy[(r + DEPTH - k) % DEPTH][c];
      column[WIN-1] = px;
      line_copy[r % DEPTH][c] = px;
      for (i = 0; i < WIN; i++) begin
         for (j = 0; j < WIN - 1; j++) window_copy[i][j] = window_copy[i][j+1];
         window_copy[i][WIN-1] = column[i];
      end
      // Rank of the centre pixel within a complete window, scaled and rounded.
      if (r >= WIN - 1 && c >= WIN - 1) begin
         centre = window_copy[HALF][HALF];
         count  = 0;
         for (i = 0; i < WIN; i++) begin
            for (j = 0; j < WIN; j++) begin
               if (window_copy[i][j] <= centre) count++;
            end
         end
         res.level = PIXEL_W'((count * FULL_SCALE + AREA / 2) / AREA);
         res.last  = (r == height_reg - 1) && (c == eff_w - 1);
         expected_q.push_back(res);
      end
      if (c + 1 >= eff_w) begin
         next_col = 0;
         next_row = r + 1;
      end else begin
         next_col = c + 1;
      end
   endfunction

   // Each accepted result is compared with the oldest prediction.
   always @(posedge clock) begin
      equalised_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            note_fault($sformatf("result with none expected: pixel %0d last %0b",
                                 rsp_tdata, rsp_tlast));
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata !== want.level || rsp_tlast !== want.last) begin
               note_fault($sformatf("expected pixel %0d last %0b, got pixel %0d last %0b",
                                    want.level, want.last, rsp_tdata, rsp_tlast));
            end
         end
      end
   end

   // Sends one pixel request, now and then with a random gap before it, and predicts its result.
   task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic sof);
      if ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      equalise_pixel(px, sof);
   endtask

   // Stops sending and waits until every predicted result has arrived.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers are only written once the block has drained.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_PADDED_WIDTH) width_reg = value[WIDTH_W-1:0];
      else height_reg = value;
   endtask

   task automatic set_geometry(input int unsigned cols, input int unsigned rows);
      write_register(CSR_PADDED_WIDTH, cols[CSR_DATA_W-1:0]);
      write_register(CSR_PADDED_HEIGHT, rows[CSR_DATA_W-1:0]);
   endtask

   function automatic logic [PIXEL_W-1:0] pick_level(texture_type tex,
                                                     logic [PIXEL_W-1:0] base);
      logic [PIXEL_W-1:0] level;
      case (tex)
         FULL_RANGE: level = PIXEL_W'($urandom_range(FULL_SCALE, 0));
         NARROW: begin
            if (base > FULL_SCALE - 8) level = base - PIXEL_W'($urandom_range(7, 0));
            else level = base + PIXEL_W'($urandom_range(7, 0));
         end
         default: begin
            case ($urandom_range(2, 0))
               0: level = '0;
               1: level = PIXEL_W'(FULL_SCALE);
               default: level = base;
            endcase
         end
      endcase
      return level;
   endfunction

   // Sends a number of pixels of one texture, the first one flagged as frame start.
   task automatic send_frame(input int unsigned total, input texture_type tex);
      logic [PIXEL_W-1:0] base;
      int unsigned        p;
      base = PIXEL_W'($urandom_range(FULL_SCALE, 0));
      for (p = 0; p < total; p++) send_pixel(pick_level(tex, base), p == 0);
   endtask

   // Reset geometry: the start of a frame, too short to complete a window.
   task automatic test_default_width();
      send_frame(9 * WIN + 1, FULL_RANGE);
      wait_for_results();
   endtask

   // Smallest frames: a lone dark centre, then a bright centre among black and white.
   task automatic test_rank_extremes();
      int unsigned p;
      set_geometry(WIN, WIN);
      for (p = 0; p < AREA; p++) send_pixel((p == CENTRE_INDEX) ? 8'd0 : 8'd255, p == 0);
      for (p = 0; p < AREA; p++) begin
         send_pixel((p == CENTRE_INDEX || p % 2 == 0) ? 8'd255 : 8'd0, p == 0);
      end
      wait_for_results();
   endtask

   // Frame restarted part way, then pixels past the frame end, then a fresh frame.
   task automatic test_frame_control();
      set_geometry(WIN + 1, WIN);
      send_frame(20, FULL_RANGE);
      send_frame((WIN + 1) * WIN + 4, FULL_RANGE);
      send_pixel(8'd77, 1'b0);
      send_frame((WIN + 1) * WIN, THREE_LEVEL);
      wait_for_results();
   endtask

   // Widths and heights too small for a window, stray upper bits and the tallest frame.
   task automatic test_odd_geometry();
      set_geometry(0, WIN);
      send_frame(WIN, FULL_RANGE);
      set_geometry(1, WIN + 1);
      send_frame(WIN + 1, FULL_RANGE);
      set_geometry(2, WIN);
      send_frame(2 * WIN, FULL_RANGE);
      set_geometry(WIN - 1, WIN + 2);
      send_frame((WIN - 1) * (WIN + 2), NARROW);
      set_geometry(WIN, WIN - 1);
      send_frame(WIN * (WIN - 1), NARROW);
      set_geometry(WIN + 2, 0);
      send_frame(WIN + 2, FULL_RANGE);
      wait_for_results();
      set_geometry(16'hF808, WIN);
      send_frame(8 * WIN, THREE_LEVEL);
      wait_for_results();
      set_geometry(WIN + 1, 16'hFFFF);
      send_frame((WIN + 1) * (WIN + 2), FULL_RANGE);
      wait_for_results();
   endtask

   // The width shrinks part way through a frame while the column counter is past it.
   task automatic test_width_shrink();
      int unsigned p;
      set_geometry(12, 10);
      for (p = 0; p < 12 * 8 + 10; p++) begin
         send_pixel(PIXEL_W'($urandom_range(FULL_SCALE, 0)), p == 0);
      end
      wait_for_results();
      write_register(CSR_PADDED_WIDTH, 16'd9);
      for (p = 0; p < 10; p++) send_pixel(PIXEL_W'($urandom_range(FULL_SCALE, 0)), 1'b0);
      wait_for_results();
   endtask

   // The width register above the line store size, with the start of a frame.
   task automatic test_width_clamp();
      set_geometry(2047, WIN);
      send_frame(9 * WIN + 1, NARROW);
      wait_for_results();
   endtask

   // Random frames: mostly whole frames, some cut short, some with pixels past the end.
   task automatic test_random_frames(input int unsigned goal);
      int unsigned stop_at, cols, rows, total, roll, p;
      texture_type tex;
      logic [PIXEL_W-1:0] base;
      stop_at = taken_pixels + goal;
      while (taken_pixels < stop_at) begin
         roll = $urandom_range(99, 0);
         if (roll < 75) cols = $urandom_range(24, WIN);
         else if (roll < 90) cols = $urandom_range(64, 25);
         else cols = $urandom_range(WIN - 1, 0);
         if ($urandom_range(9, 0) == 0) rows = $urandom_range(WIN - 1, 0);
         else rows = $urandom_range(WIN + 4, WIN);
         set_geometry(cols, rows);
         total = ((cols == 0) ? 1 : cols) * ((rows == 0) ? 1 : rows);
         roll  = $urandom_range(9, 0);
         if (roll == 0) total = $urandom_range(total, 1);
         else if (roll == 1) total = total + $urandom_range(5, 1);
         tex  = texture_type'($urandom_range(2, 0));
         base = PIXEL_W'($urandom_range(FULL_SCALE, 0));
         for (p = 0; p < total; p++) begin
            send_pixel(pick_level(tex, base), p == 0);
            // Now and then the sender holds off until the block has drained.
            if ($urandom_range(299, 0) == 0) wait_for_results();
         end
         wait_for_results();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_default_width();
      test_rank_extremes();
      test_frame_control();
      test_odd_geometry();
      test_width_shrink();
      test_random_frames(200);
      send_idle_pct = 76;
      recv_idle_pct = 18;
      test_random_frames(200);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(200);
      test_width_clamp();
      wait_for_results();
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
